>>> rtl/core/slx_pkg.sv
package slx_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int FIELD_WIDTH  = 16;
    localparam int MAX_RESULTS  = 4;
    localparam int PREFIX_DEPTH = 7;

    typedef logic [OFFSET_WIDTH-1:0] t_offset;
    localparam t_offset OFFSET_MAX = '1;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    localparam logic [5:0] K_EOF     = 6'd16;
    localparam logic [5:0] K_LPAREN  = 6'd17;
    localparam logic [5:0] K_RPAREN  = 6'd18;
    localparam logic [5:0] K_LBRACE  = 6'd19;
    localparam logic [5:0] K_RBRACE  = 6'd20;
    localparam logic [5:0] K_COMMA   = 6'd21;
    localparam logic [5:0] K_DOT     = 6'd22;
    localparam logic [5:0] K_MINUS   = 6'd23;
    localparam logic [5:0] K_PLUS    = 6'd24;
    localparam logic [5:0] K_SEMI    = 6'd25;
    localparam logic [5:0] K_STAR    = 6'd26;
    localparam logic [5:0] K_BANG_EQ = 6'd27;
    localparam logic [5:0] K_BANG    = 6'd28;
    localparam logic [5:0] K_EQ_EQ   = 6'd29;
    localparam logic [5:0] K_EQ      = 6'd30;
    localparam logic [5:0] K_LESS_EQ = 6'd31;
    localparam logic [5:0] K_LESS    = 6'd32;
    localparam logic [5:0] K_GT_EQ   = 6'd33;
    localparam logic [5:0] K_GT      = 6'd34;
    localparam logic [5:0] K_SLASH   = 6'd35;
    localparam logic [5:0] K_NUMBER  = 6'd36;
    localparam logic [5:0] K_IDENT   = 6'd37;
    localparam logic [5:0] K_STRING  = 6'd38;
    localparam logic [5:0] K_BAD     = 6'd39;
    localparam logic [5:0] K_UNTERM  = 6'd40;

    typedef enum logic [3:0] {
        M_IDLE, M_BANG, M_EQ, M_LESS, M_GREATER, M_SLASH, M_COMMENT,
        M_STRING, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_IDENT
    } t_mode;

    typedef struct packed {
        logic [5:0]             kind;
        logic [FIELD_WIDTH-1:0] start;
        logic [FIELD_WIDTH-1:0] len;
        logic [FIELD_WIDTH-1:0] line;
    } t_result;

    typedef struct packed {
        logic [2:0]                      n;
        t_result [MAX_RESULTS-1:0]       res;
    } t_bundle;

    typedef logic [PREFIX_DEPTH-1:0][7:0] t_prefix;

    function automatic t_offset sat_inc(input t_offset v);
        return (v == OFFSET_MAX) ? v : v + t_offset'(1);
    endfunction

    function automatic logic [55:0] kw_text(input logic [3:0] k);
        case (k)
            4'd0:    kw_text = 56'("fi");
            4'd1:    kw_text = 56'("gita");
            4'd2:    kw_text = 56'("taanan");
            4'd3:    kw_text = 56'("soba");
            4'd4:    kw_text = 56'("hojii");
            4'd5:    kw_text = 56'("yeroof");
            4'd6:    kw_text = 56'("yoo");
            4'd7:    kw_text = 56'("duwwa");
            4'd8:    kw_text = 56'("ykn");
            4'd9:    kw_text = 56'("baasi");
            4'd10:   kw_text = 56'("deebisi");
            4'd11:   kw_text = 56'("guddoo");
            4'd12:   kw_text = 56'("kana");
            4'd13:   kw_text = 56'("dhugaa");
            4'd14:   kw_text = 56'("maqaa");
            default: kw_text = 56'("yeroo");
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] k);
        case (k)
            4'd0:    kw_len = 3'd2;
            4'd1:    kw_len = 3'd4;
            4'd2:    kw_len = 3'd6;
            4'd3:    kw_len = 3'd4;
            4'd4:    kw_len = 3'd5;
            4'd5:    kw_len = 3'd6;
            4'd6:    kw_len = 3'd3;
            4'd7:    kw_len = 3'd5;
            4'd8:    kw_len = 3'd3;
            4'd9:    kw_len = 3'd5;
            4'd10:   kw_len = 3'd7;
            4'd11:   kw_len = 3'd6;
            4'd12:   kw_len = 3'd4;
            4'd13:   kw_len = 3'd6;
            4'd14:   kw_len = 3'd5;
            default: kw_len = 3'd5;
        endcase
    endfunction

    // parallel compare against all keywords, lowest keyword index wins
    function automatic logic [5:0] word_kind(input t_prefix wp, input logic [3:0] wl);
        logic [5:0]  kind;
        logic        same;
        logic [55:0] txt;
        logic [2:0]  kl;
        kind = K_IDENT;
        for (int k = 15; k >= 0; k--) begin
            txt  = kw_text(4'(k));
            kl   = kw_len(4'(k));
            same = ({1'b0, kl} == wl);
            for (int i = 0; i < PREFIX_DEPTH; i++) begin
                if (i < int'(kl) && wp[i] != txt[8*(int'(kl)-1-i) +: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                kind = 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic t_result mk(input logic [5:0] kind, input t_offset start,
                                   input t_offset len, input logic [15:0] line);
        t_result r;
        r.kind  = kind;
        r.start = FIELD_WIDTH'(start);
        r.len   = FIELD_WIDTH'(len);
        r.line  = line;
        return r;
    endfunction

    // fixed length one or two tokens
    function automatic t_result mk1(input logic [5:0] kind, input t_offset start,
                                    input logic [15:0] line);
        return mk(kind, start, t_offset'(1), line);
    endfunction

    function automatic t_result mk2(input logic [5:0] kind, input t_offset start,
                                    input logic [15:0] line);
        return mk(kind, start, t_offset'(2), line);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

endpackage

>>> rtl/core/script_lexer_tokenizer.sv
// source byte scanner producing tokens (kind, start offset, length, line)
// input channel: i_valid/o_ready carries one byte (i_char_code with
// i_char_present) and an end flag i_is_end; a transfer with neither byte
// nor end does nothing
// output channel: o_valid/i_ready carries one token per transfer; o_last
// marks the final token caused by one input transfer (up to 4 per input)
// a token is written into the registered result queue by the input transfer that
// completes it; operators and words wait for the byte that ends them
// throughput: one input per cycle while each input gives at most one
// token and i_ready stays high; an input's n tokens leave one per transfer
// the scanner writes whole result groups into a two-entry queue, so it
// keeps accepting bytes while the receiver holds a token back; when the
// queue fills, o_ready drops until the receiver takes the head group
// reset: synchronous active low; scanner returns to idle, offset 0, line 1,
// queue empty; after an end transfer the scanner is in the same state
module script_lexer_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_char_present,
    input  logic        i_is_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_lexeme_length,
    output logic [15:0] o_line_number,
    output logic        o_last
);

    logic             q_ready;
    logic             q_push;
    slx_pkg::t_bundle q_data;
    slx_pkg::t_result result;

    slx_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .i_is_end       (i_is_end),
        .i_q_ready      (q_ready),
        .o_q_push       (q_push),
        .o_q_data       (q_data)
    );

    slx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_push  (q_push),
        .i_q_data  (q_data),
        .o_q_ready (q_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result),
        .o_last    (o_last)
    );

    assign o_token_kind    = result.kind;
    assign o_start_offset  = result.start;
    assign o_lexeme_length = result.len;
    assign o_line_number   = result.line;

endmodule

>>> rtl/core/slx_front.sv
module slx_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_char_code,
    input  logic             i_char_present,
    input  logic             i_is_end,
    input  logic             i_q_ready,
    output logic             o_q_push,
    output slx_pkg::t_bundle o_q_data
);

    slx_pkg::t_mode   r_mode, n_mode;
    slx_pkg::t_offset r_tstart, n_tstart;
    slx_pkg::t_offset r_pos, n_pos;
    logic [15:0]      r_line, n_line;
    slx_pkg::t_prefix r_wp, n_wp;
    logic [3:0]       r_wlen, n_wlen;
    slx_pkg::t_bundle n_bundle;

    // scanner next state and the results this byte and end flag cause
    always_comb begin
        logic [2:0]       cnt;
        logic             used;
        logic [7:0]       c;
        slx_pkg::t_offset p;
        slx_pkg::t_offset dotp;
        slx_pkg::t_mode   cm;
        logic             do_close;
        n_mode   = r_mode;
        n_tstart = r_tstart;
        n_pos    = r_pos;
        n_line   = r_line;
        n_wp     = r_wp;
        n_wlen   = r_wlen;
        n_bundle = '0;
        cnt      = '0;
        used     = 1'b1;
        c        = i_char_code;
        p        = r_pos;
        do_close = 1'b0;
        cm       = slx_pkg::M_IDLE;
        dotp     = '0;
        if (i_char_present) begin
            case (r_mode)
                slx_pkg::M_BANG, slx_pkg::M_EQ, slx_pkg::M_LESS, slx_pkg::M_GREATER: begin
                    if (c == "=") begin
                        case (r_mode)
                            slx_pkg::M_BANG: n_bundle.res[cnt[1:0]] =
                                slx_pkg::mk2(slx_pkg::K_BANG_EQ, r_tstart, n_line);
                            slx_pkg::M_EQ: n_bundle.res[cnt[1:0]] =
                                slx_pkg::mk2(slx_pkg::K_EQ_EQ, r_tstart, n_line);
                            slx_pkg::M_LESS: n_bundle.res[cnt[1:0]] =
                                slx_pkg::mk2(slx_pkg::K_LESS_EQ, r_tstart, n_line);
                            default: n_bundle.res[cnt[1:0]] =
                                slx_pkg::mk2(slx_pkg::K_GT_EQ, r_tstart, n_line);
                        endcase
                        cnt    = cnt + 3'd1;
                        n_mode = slx_pkg::M_IDLE;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                slx_pkg::M_SLASH: begin
                    if (c == "/") n_mode = slx_pkg::M_COMMENT;
                    else do_close = 1'b1;
                end
                slx_pkg::M_COMMENT: begin
                    if (c == 8'h0A) begin
                        n_mode = slx_pkg::M_IDLE;
                        used   = 1'b0;
                    end
                end
                slx_pkg::M_STRING: begin
                    if (c == "\"") begin
                        n_bundle.res[cnt[1:0]] =
                            slx_pkg::mk(slx_pkg::K_STRING, r_tstart, p - r_tstart, n_line);
                        cnt    = cnt + 3'd1;
                        n_mode = slx_pkg::M_IDLE;
                    end else if (c == 8'h0A && n_line != slx_pkg::LINE_MAX) begin
                        n_line = n_line + 16'd1;
                    end
                end
                slx_pkg::M_NUM_INT: begin
                    if (c == ".") n_mode = slx_pkg::M_NUM_DOT;
                    else if (!slx_pkg::is_digit(c)) do_close = 1'b1;
                end
                slx_pkg::M_NUM_DOT: begin
                    if (slx_pkg::is_digit(c)) n_mode = slx_pkg::M_NUM_FRAC;
                    else do_close = 1'b1;
                end
                slx_pkg::M_NUM_FRAC: begin
                    if (!slx_pkg::is_digit(c)) do_close = 1'b1;
                end
                slx_pkg::M_IDENT: begin
                    if (slx_pkg::is_alpha(c) || slx_pkg::is_digit(c)) begin
                        if (r_wlen < 4'd7) begin
                            n_wp[r_wlen[2:0]] = c;
                            n_wlen = r_wlen + 4'd1;
                        end else begin
                            n_wlen = 4'd8;
                        end
                    end else begin
                        do_close = 1'b1;
                    end
                end
                default: begin
                    n_mode = slx_pkg::M_IDLE;
                    used   = 1'b0;
                end
            endcase
            if (do_close) begin
                used = 1'b0;
                case (r_mode)
                    slx_pkg::M_BANG: begin
                        n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_BANG, r_tstart, n_line);
                        cnt = cnt + 3'd1;
                    end
                    slx_pkg::M_EQ: begin
                        n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_EQ, r_tstart, n_line);
                        cnt = cnt + 3'd1;
                    end
                    slx_pkg::M_LESS: begin
                        n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_LESS, r_tstart, n_line);
                        cnt = cnt + 3'd1;
                    end
                    slx_pkg::M_GREATER: begin
                        n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_GT, r_tstart, n_line);
                        cnt = cnt + 3'd1;
                    end
                    slx_pkg::M_SLASH: begin
                        n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_SLASH, r_tstart, n_line);
                        cnt = cnt + 3'd1;
                    end
                    slx_pkg::M_NUM_DOT: begin
                        dotp = (p > r_tstart) ? p - slx_pkg::t_offset'(1) : p;
                        n_bundle.res[cnt[1:0]] =
                            slx_pkg::mk(slx_pkg::K_NUMBER, r_tstart, dotp - r_tstart, n_line);
                        cnt = cnt + 3'd1;
                        n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_DOT, dotp, n_line);
                        cnt = cnt + 3'd1;
                    end
                    slx_pkg::M_IDENT: begin
                        n_bundle.res[cnt[1:0]] = slx_pkg::mk(slx_pkg::word_kind(r_wp, r_wlen),
                                                             r_tstart, p - r_tstart, n_line);
                        cnt = cnt + 3'd1;
                    end
                    default: begin
                        n_bundle.res[cnt[1:0]] =
                            slx_pkg::mk(slx_pkg::K_NUMBER, r_tstart, p - r_tstart, n_line);
                        cnt = cnt + 3'd1;
                    end
                endcase
                n_mode = slx_pkg::M_IDLE;
            end
            if (!used) begin
                n_tstart = p;
                case (c)
                    "(": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_LPAREN, p, n_line);
                         cnt = cnt + 3'd1; end
                    ")": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_RPAREN, p, n_line);
                         cnt = cnt + 3'd1; end
                    "{": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_LBRACE, p, n_line);
                         cnt = cnt + 3'd1; end
                    "}": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_RBRACE, p, n_line);
                         cnt = cnt + 3'd1; end
                    ",": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_COMMA, p, n_line);
                         cnt = cnt + 3'd1; end
                    ".": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_DOT, p, n_line);
                         cnt = cnt + 3'd1; end
                    "-": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_MINUS, p, n_line);
                         cnt = cnt + 3'd1; end
                    "+": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_PLUS, p, n_line);
                         cnt = cnt + 3'd1; end
                    ";": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_SEMI, p, n_line);
                         cnt = cnt + 3'd1; end
                    "*": begin n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_STAR, p, n_line);
                         cnt = cnt + 3'd1; end
                    "!": n_mode = slx_pkg::M_BANG;
                    "=": n_mode = slx_pkg::M_EQ;
                    "<": n_mode = slx_pkg::M_LESS;
                    ">": n_mode = slx_pkg::M_GREATER;
                    "/": n_mode = slx_pkg::M_SLASH;
                    " ", 8'h0D, 8'h09: ;
                    8'h0A: begin
                        if (n_line != slx_pkg::LINE_MAX) n_line = n_line + 16'd1;
                    end
                    "\"": begin
                        n_tstart = slx_pkg::sat_inc(p);
                        n_mode   = slx_pkg::M_STRING;
                    end
                    default: begin
                        if (slx_pkg::is_digit(c)) begin
                            n_mode = slx_pkg::M_NUM_INT;
                        end else if (slx_pkg::is_alpha(c)) begin
                            n_wp[0] = c;
                            n_wlen  = 4'd1;
                            n_mode  = slx_pkg::M_IDENT;
                        end else begin
                            n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_BAD, p, n_line);
                            cnt = cnt + 3'd1;
                        end
                    end
                endcase
            end
            n_pos = slx_pkg::sat_inc(p);
        end
        if (i_is_end) begin
            cm = n_mode;
            p  = n_pos;
            case (cm)
                slx_pkg::M_STRING: begin
                    n_bundle.res[cnt[1:0]] =
                        slx_pkg::mk(slx_pkg::K_UNTERM, n_tstart, p - n_tstart, n_line);
                    cnt = cnt + 3'd1;
                end
                slx_pkg::M_BANG: begin
                    n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_BANG, n_tstart, n_line);
                    cnt = cnt + 3'd1;
                end
                slx_pkg::M_EQ: begin
                    n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_EQ, n_tstart, n_line);
                    cnt = cnt + 3'd1;
                end
                slx_pkg::M_LESS: begin
                    n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_LESS, n_tstart, n_line);
                    cnt = cnt + 3'd1;
                end
                slx_pkg::M_GREATER: begin
                    n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_GT, n_tstart, n_line);
                    cnt = cnt + 3'd1;
                end
                slx_pkg::M_SLASH: begin
                    n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_SLASH, n_tstart, n_line);
                    cnt = cnt + 3'd1;
                end
                slx_pkg::M_NUM_INT, slx_pkg::M_NUM_FRAC: begin
                    n_bundle.res[cnt[1:0]] =
                        slx_pkg::mk(slx_pkg::K_NUMBER, n_tstart, p - n_tstart, n_line);
                    cnt = cnt + 3'd1;
                end
                slx_pkg::M_NUM_DOT: begin
                    dotp = (p > n_tstart) ? p - slx_pkg::t_offset'(1) : p;
                    n_bundle.res[cnt[1:0]] =
                        slx_pkg::mk(slx_pkg::K_NUMBER, n_tstart, dotp - n_tstart, n_line);
                    cnt = cnt + 3'd1;
                    n_bundle.res[cnt[1:0]] = slx_pkg::mk1(slx_pkg::K_DOT, dotp, n_line);
                    cnt = cnt + 3'd1;
                end
                slx_pkg::M_IDENT: begin
                    n_bundle.res[cnt[1:0]] = slx_pkg::mk(slx_pkg::word_kind(n_wp, n_wlen),
                                                         n_tstart, p - n_tstart, n_line);
                    cnt = cnt + 3'd1;
                end
                default: ;
            endcase
            n_bundle.res[cnt[1:0]] = slx_pkg::mk(slx_pkg::K_EOF, p, '0, n_line);
            cnt      = cnt + 3'd1;
            n_mode   = slx_pkg::M_IDLE;
            n_tstart = '0;
            n_pos    = '0;
            n_line   = 16'd1;
            n_wlen   = '0;
        end
        n_bundle.n = cnt;
    end

    assign o_ready  = i_q_ready;
    assign o_q_push = i_valid && i_q_ready && (n_bundle.n != 3'd0);
    assign o_q_data = n_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= slx_pkg::M_IDLE;
            r_tstart <= '0;
            r_pos    <= '0;
            r_line   <= 16'd1;
            r_wlen   <= '0;
        end else if (i_valid && i_q_ready) begin
            r_mode   <= n_mode;
            r_tstart <= n_tstart;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_wlen   <= n_wlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_q_ready) begin
            r_wp <= n_wp;
        end
    end

endmodule

>>> rtl/core/slx_back.sv
module slx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_push,
    input  slx_pkg::t_bundle i_q_data,
    output logic             o_q_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output slx_pkg::t_result o_result,
    output logic             o_last
);

    slx_pkg::t_bundle r_q [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_count, n_count;
    logic [1:0]       r_idx, n_idx;
    logic             n_wr, n_rd;
    logic             pop;
    slx_pkg::t_bundle head;

    assign head      = r_q[r_rd];
    assign o_valid   = (r_count != 2'd0);
    assign o_q_ready = (r_count != 2'd2);
    assign o_result  = head.res[r_idx];
    assign o_last    = ({1'b0, r_idx} == head.n - 3'd1);
    assign pop       = o_valid && i_ready && o_last;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_idx   = r_idx;
        n_count = r_count;
        if (i_q_push) begin
            n_wr = ~r_wr;
        end
        if (o_valid && i_ready) begin
            if (pop) begin
                n_idx = '0;
                n_rd  = ~r_rd;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        n_count = r_count + {1'b0, i_q_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_push) begin
            r_q[r_wr] <= i_q_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_push |-> r_count != 2'd2)
        else $error("queue push while full");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> head.n != 3'd0 && head.n <= 3'd4)
        else $error("queued bundle has no results");

    a_idx_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_idx) && $stable(r_rd))
        else $error("result index moved during stall");

endmodule

>>> tb/sv/script_lexer_tokenizer_test.sv
`timescale 1ns / 100ps

module script_lexer_tokenizer_test;

    typedef struct packed {
        logic [7:0] code;
        logic       present;
        logic       is_end;
    } t_byte_item;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_token;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_char_code;
    logic        i_char_present;
    logic        i_is_end;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_token_kind;
    logic [15:0] o_start_offset;
    logic [15:0] o_lexeme_length;
    logic [15:0] o_line_number;
    logic        o_last;

    script_lexer_tokenizer u_top (.*);

    // scanner copy used to predict tokens
    slx_pkg::t_mode lx_mode;
    logic [15:0]    lx_start;
    logic [15:0]    lx_pos;
    logic [15:0]    lx_line;
    logic [7:0]     lx_word [7];
    int             lx_wlen;

    t_byte_item pending_bytes [$];
    t_token     expected_tokens [$];
    int         n_fail;
    int         n_tokens;
    int         n_bytes;
    int         cycle_count;
    bit         stim_done;
    bit         calm;
    int         src_gap;
    int         sink_gap;
    int         hold_off;
    bit         hold_done;

    string keywords [16] = '{"fi", "gita", "taanan", "soba", "hojii", "yeroof", "yoo",
        "duwwa", "ykn", "baasi", "deebisi", "guddoo", "kana", "dhugaa", "maqaa", "yeroo"};

    initial i_clk = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_fail++;
        $display("mismatch %0s: got %0d expected %0d (token %0d)", what, got, want, n_tokens);
    endtask

    function automatic bit digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alpha_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [15:0] inc_sat(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic push_token(input logic [5:0] k, input logic [15:0] s, input logic [15:0] l,
                              inout int cnt);
        t_token t;
        if (cnt >= 4) return;
        t.kind = k; t.start = s; t.len = l; t.line = lx_line; t.last = 1'b0;
        expected_tokens.push_back(t);
        cnt++;
    endtask

    function automatic logic [5:0] classify_word();
        string w;
        if (lx_wlen == 0 || lx_wlen > 7) return slx_pkg::K_IDENT;
        w = "";
        for (int i = 0; i < lx_wlen; i++) w = {w, string'(lx_word[i])};
        for (int k = 0; k < 16; k++)
            if (keywords[k] == w) return 6'(k);
        return slx_pkg::K_IDENT;
    endfunction

    task automatic flush_pending(input logic [15:0] p, inout int cnt);
        logic [15:0] dp;
        case (lx_mode)
            slx_pkg::M_BANG:    push_token(slx_pkg::K_BANG, lx_start, 16'd1, cnt);
            slx_pkg::M_EQ:      push_token(slx_pkg::K_EQ, lx_start, 16'd1, cnt);
            slx_pkg::M_LESS:    push_token(slx_pkg::K_LESS, lx_start, 16'd1, cnt);
            slx_pkg::M_GREATER: push_token(slx_pkg::K_GT, lx_start, 16'd1, cnt);
            slx_pkg::M_SLASH:   push_token(slx_pkg::K_SLASH, lx_start, 16'd1, cnt);
            slx_pkg::M_NUM_INT, slx_pkg::M_NUM_FRAC:
                push_token(slx_pkg::K_NUMBER, lx_start, p - lx_start, cnt);
            slx_pkg::M_NUM_DOT: begin
                dp = (p > lx_start) ? p - 16'd1 : p;
                push_token(slx_pkg::K_NUMBER, lx_start, dp - lx_start, cnt);
                push_token(slx_pkg::K_DOT, dp, 16'd1, cnt);
            end
            slx_pkg::M_IDENT:   push_token(classify_word(), lx_start, p - lx_start, cnt);
            default: ;
        endcase
        lx_mode = slx_pkg::M_IDLE;
    endtask

    task automatic scan_fresh(input logic [7:0] c, input logic [15:0] p, inout int cnt);
        lx_start = p;
        case (c)
            "(": push_token(slx_pkg::K_LPAREN, p, 16'd1, cnt);
            ")": push_token(slx_pkg::K_RPAREN, p, 16'd1, cnt);
            "{": push_token(slx_pkg::K_LBRACE, p, 16'd1, cnt);
            "}": push_token(slx_pkg::K_RBRACE, p, 16'd1, cnt);
            ",": push_token(slx_pkg::K_COMMA, p, 16'd1, cnt);
            ".": push_token(slx_pkg::K_DOT, p, 16'd1, cnt);
            "-": push_token(slx_pkg::K_MINUS, p, 16'd1, cnt);
            "+": push_token(slx_pkg::K_PLUS, p, 16'd1, cnt);
            ";": push_token(slx_pkg::K_SEMI, p, 16'd1, cnt);
            "*": push_token(slx_pkg::K_STAR, p, 16'd1, cnt);
            "!": lx_mode = slx_pkg::M_BANG;
            "=": lx_mode = slx_pkg::M_EQ;
            "<": lx_mode = slx_pkg::M_LESS;
            ">": lx_mode = slx_pkg::M_GREATER;
            "/": lx_mode = slx_pkg::M_SLASH;
            " ", 8'h0D, 8'h09: ;
            8'h0A: if (lx_line != 16'hFFFF) lx_line++;
            8'h22: begin
                lx_start = inc_sat(p);
                lx_mode = slx_pkg::M_STRING;
            end
            default: begin
                if (digit_c(c)) begin
                    lx_mode = slx_pkg::M_NUM_INT;
                end else if (alpha_c(c)) begin
                    lx_word[0] = c;
                    lx_wlen = 1;
                    lx_mode = slx_pkg::M_IDENT;
                end else begin
                    push_token(slx_pkg::K_BAD, p, 16'd1, cnt);
                end
            end
        endcase
    endtask

    task automatic clear_scanner();
        lx_mode = slx_pkg::M_IDLE; lx_start = '0; lx_pos = '0; lx_line = 16'd1; lx_wlen = 0;
    endtask

    task automatic predict_tokens(input t_byte_item it);
        int          cnt;
        bit          used;
        logic [15:0] p;
        logic [7:0]  c;
        cnt = 0;
        c = it.code;
        if (it.present) begin
            p = lx_pos;
            used = 1'b1;
            case (lx_mode)
                slx_pkg::M_BANG, slx_pkg::M_EQ, slx_pkg::M_LESS, slx_pkg::M_GREATER: begin
                    if (c == "=") begin
                        push_token(slx_pkg::K_BANG_EQ
                                   + 6'(2 * (int'(lx_mode) - int'(slx_pkg::M_BANG))),
                                   lx_start, 16'd2, cnt);
                        lx_mode = slx_pkg::M_IDLE;
                    end else begin
                        flush_pending(p, cnt); used = 1'b0;
                    end
                end
                slx_pkg::M_SLASH: begin
                    if (c == "/") lx_mode = slx_pkg::M_COMMENT;
                    else begin flush_pending(p, cnt); used = 1'b0; end
                end
                slx_pkg::M_COMMENT:
                    if (c == 8'h0A) begin lx_mode = slx_pkg::M_IDLE; used = 1'b0; end
                slx_pkg::M_STRING: begin
                    if (c == 8'h22) begin
                        push_token(slx_pkg::K_STRING, lx_start, p - lx_start, cnt);
                        lx_mode = slx_pkg::M_IDLE;
                    end else if (c == 8'h0A && lx_line != 16'hFFFF) begin
                        lx_line++;
                    end
                end
                slx_pkg::M_NUM_INT: begin
                    if (c == ".") lx_mode = slx_pkg::M_NUM_DOT;
                    else if (!digit_c(c)) begin flush_pending(p, cnt); used = 1'b0; end
                end
                slx_pkg::M_NUM_DOT: begin
                    if (digit_c(c)) lx_mode = slx_pkg::M_NUM_FRAC;
                    else begin flush_pending(p, cnt); used = 1'b0; end
                end
                slx_pkg::M_NUM_FRAC:
                    if (!digit_c(c)) begin flush_pending(p, cnt); used = 1'b0; end
                slx_pkg::M_IDENT: begin
                    if (alpha_c(c) || digit_c(c)) begin
                        if (lx_wlen < 7) begin
                            lx_word[lx_wlen] = c;
                            lx_wlen++;
                        end else begin
                            lx_wlen = 8;
                        end
                    end else begin
                        flush_pending(p, cnt); used = 1'b0;
                    end
                end
                default: begin lx_mode = slx_pkg::M_IDLE; used = 1'b0; end
            endcase
            if (!used) scan_fresh(c, p, cnt);
            lx_pos = inc_sat(p);
        end
        if (it.is_end) begin
            if (lx_mode == slx_pkg::M_STRING)
                push_token(slx_pkg::K_UNTERM, lx_start, lx_pos - lx_start, cnt);
            else if (lx_mode != slx_pkg::M_COMMENT) flush_pending(lx_pos, cnt);
            push_token(slx_pkg::K_EOF, lx_pos, 16'd0, cnt);
            clear_scanner();
        end
        if (cnt > 0) expected_tokens[$].last = 1'b1;
    endtask

    task automatic add_byte(input logic [7:0] c);
        t_byte_item it;
        it.code = c; it.present = 1'b1; it.is_end = 1'b0;
        pending_bytes.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_end(input bit with_byte, input logic [7:0] c);
        t_byte_item it;
        it.code = c; it.present = with_byte; it.is_end = 1'b1;
        pending_bytes.push_back(it);
    endtask

    function automatic string random_lexeme();
        string s;
        int    n;
        case ($urandom_range(0, 11))
            0, 1: s = keywords[$urandom_range(0, 15)];
            2: begin
                s = "";
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(0, 1) ? $urandom_range(97, 122)
                                                            : $urandom_range(48, 57)))};
                s = {"_", s};
            end
            3: s = $sformatf("%0d", $urandom_range(0, 99999));
            4: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
            5: s = $sformatf("%0d.", $urandom_range(0, 99));
            6: begin
                string ops [11] = '{"!", "!=", "=", "==", "<", "<=", ">", ">=", "/",
                                    "(", "*"};
                s = ops[$urandom_range(0, 10)];
            end
            7: begin
                if ($urandom_range(0, 1)) s = "\"ab\n\"";
                else s = "\"ab x\"";
            end
            8: s = "// note ;\n";
            9: s = "\n";
            10: s = string'(8'($urandom_range(0, 255)));
            default: s = " ";
        endcase
        return s;
    endfunction

    initial begin
        int budget;
        clear_scanner();
        // directed: every single-character token, operators, comment, string, number forms
        add_text("(){},.-+;*! != = == < <= > >= / //c\n\"s\ntr\" 12.5 7.x 9. ");
        add_text("fi deebisi abcdefgh Z9_ @");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_text("\t\r\"open");
        add_end(1'b1, "q");
        add_text("ab");
        add_end(1'b1, "=");
        add_end(1'b0, 8'h00);
        pending_bytes.push_back('{8'hA5, 1'b0, 1'b0});
        add_text("x/");
        add_end(1'b0, 8'h5A);
        // random source text, ended now and then
        budget = 410;
        while (budget > 0) begin
            string s;
            s = random_lexeme();
            add_text(s);
            budget -= s.len();
            if ($urandom_range(0, 40) == 0) add_end($urandom_range(0, 1), 8'($urandom));
            if ($urandom_range(0, 60) == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
        end
        add_end(1'b0, 8'h00);
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_char_code <= '0;
            i_char_present <= 1'b0;
            i_is_end <= 1'b0;
            src_gap <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                t_byte_item done_it;
                done_it.code = i_char_code;
                done_it.present = i_char_present;
                done_it.is_end = i_is_end;
                predict_tokens(done_it);
                n_bytes++;
            end
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                src_gap <= $urandom_range(1, 12) - 1;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                t_byte_item it;
                it = pending_bytes.pop_front();
                i_valid <= 1'b1;
                i_char_code <= it.code;
                i_char_present <= it.present;
                i_is_end <= it.is_end;
            end else begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // one long receiver hold-off early in the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_bytes >= 40) begin
            hold_off <= 60;
            hold_done <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected token kind", o_token_kind, -1);
                end else begin
                    t_token w;
                    w = expected_tokens.pop_front();
                    if (o_token_kind != w.kind) report_mismatch("kind", o_token_kind, w.kind);
                    if (o_start_offset != w.start)
                        report_mismatch("start", o_start_offset, w.start);
                    if (o_lexeme_length != w.len)
                        report_mismatch("length", o_lexeme_length, w.len);
                    if (o_line_number != w.line) report_mismatch("line", o_line_number, w.line);
                    if (o_last != w.last) report_mismatch("last", o_last, w.last);
                end
                n_tokens++;
            end
            if (hold_off > 0) begin
                i_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 12) == 0) begin
                sink_gap <= $urandom_range(1, 12) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        n_fail = 0; n_tokens = 0; n_bytes = 0; cycle_count = 0;
        stim_done = 1'b0; calm = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && expected_tokens.size() == 0) && cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
            if (pending_bytes.size() < 60) calm = 1'b1;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d tokens outstanding", expected_tokens.size());
            $display("Verification failed");
            $finish;
        end else begin
            repeat (20) @(posedge i_clk);
            $display("scanned %0d input transfers and checked %0d tokens", n_bytes, n_tokens);
            if (n_fail == 0) $display("Verification passed");
            else $display("Verification failed");
            $finish;
        end
    end

endmodule

>>> sim.f
rtl/core/slx_pkg.sv
rtl/core/slx_front.sv
rtl/core/slx_back.sv
rtl/core/script_lexer_tokenizer.sv
tb/sv/script_lexer_tokenizer_test.sv
